// ===== rtl/mmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpq_pkg - shared types and codes for the min/max priority queue
// Record layout and request codes used by the queue, its store and its scan
// unit.
// ----------------------------------------------------------------------------
package mmpq_pkg;

   localparam int unsigned REQ_W = 3;

   localparam logic [REQ_W-1:0] REQ_PUSH     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_POP_MIN  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_MAX  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_LAST = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;

   typedef struct packed {
      logic [9:0]  cell_idx;
      logic [15:0] cost;
      logic [7:0]  turn;
      logic [7:0]  run;
   } rec_type;

   // control into the scan unit
   typedef struct packed {
      logic vld;       // read data on the memory port belongs to the scan
      logic first;     // entry zero: load unconditionally
      logic want_max;  // pick greatest cost, else least
   } scan_ctl_type;

endpackage

// ===== rtl/mmpq_mem.sv =====
// ----------------------------------------------------------------------------
// mmpq_mem - entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mmpq_mem
   import mmpq_pkg::*;
#(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned IW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  rec_type       wr_data,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output rec_type       rd_data
);

   rec_type mem_ff [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mmpq_scan.sv =====
// ----------------------------------------------------------------------------
// mmpq_scan - shared cost comparator
// Sees one stored entry per cycle and keeps the best one so far; on ties the
// later (higher index) entry wins.
// ----------------------------------------------------------------------------
module mmpq_scan
   import mmpq_pkg::*;
#(
   parameter int unsigned IW = 6
) (
   input  logic          clock,
   input  scan_ctl_type  ctl,
   input  logic [IW-1:0] idx,
   input  rec_type       rec,
   output logic [IW-1:0] best_idx,
   output rec_type       best_rec
);

   logic [IW-1:0] best_idx_ff;
   rec_type       best_rec_ff;
   logic          take;

   always_comb begin
      if (ctl.want_max) begin
         take = ctl.first || (rec.cost >= best_rec_ff.cost);
      end else begin
         take = ctl.first || (rec.cost <= best_rec_ff.cost);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.vld && take) begin
         best_idx_ff <= idx;
         best_rec_ff <= rec;
      end
   end

   assign best_idx = best_idx_ff;
   assign best_rec = best_rec_ff;

endmodule

// ===== rtl/min_max_priority_queue_top.sv =====
// Sequence: push, clear, unused codes and pops on an empty queue go from IDLE
//   straight to FINISH; pop-last passes through LAST first; pop-min/pop-max
//   pass through SCAN, which reads every stored entry, MOVE, which fills the
//   hole, and FINISH, which waits for a free output register.
// Throughput: one request at a time; the next beat is taken the cycle after
//   the result is loaded into the output register.
// Reset: synchronous, active high; empties the queue, store contents are kept.
// ----------------------------------------------------------------------------
// min_max_priority_queue_top - unsorted-array priority queue
// Flood records live unsorted in a single-port-read store. Pop-min/pop-max
// stream every entry through one shared comparator, then move the newest
// entry into the hole. Pop-last and push touch one address only.
// ----------------------------------------------------------------------------
module min_max_priority_queue_top
   import mmpq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [9:0]        req_in_cell,
   input  logic [15:0]       req_in_cost,
   input  logic [7:0]        req_in_turn,
   input  logic [7:0]        req_in_run,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_out_valid,
   output logic [9:0]        rsp_out_cell,
   output logic [15:0]       rsp_out_cost,
   output logic [7:0]        rsp_out_turn,
   output logic [7:0]        rsp_out_run,
   output logic [6:0]        rsp_occupancy,
   output logic              rsp_is_empty,
   output logic              rsp_is_full,
   output logic              rsp_push_dropped
);

   // count holds 0..QUEUE_DEPTH, address holds 0..QUEUE_DEPTH-1
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned IW = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;  // stream entries through comparator
   localparam logic [2:0] ST_MOVE   = 3'd2;  // fill the hole with newest entry
   localparam logic [2:0] ST_LAST   = 3'd3;  // wait for pop-last read data
   localparam logic [2:0] ST_FINISH = 3'd4;  // hand result to output register

   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    issue_ff, issue_in;       // next scan read address
   logic             rd_vld_ff;                 // read data valid this cycle
   logic [CW-1:0]    rd_idx_ff;                 // address of that read data during a scan
   logic             want_max_ff, want_max_in;

   // result staged before it reaches the output register
   logic             res_valid_ff, res_valid_in;
   rec_type          res_rec_ff, res_rec_in;
   logic             res_drop_ff, res_drop_in;

   // output register
   logic             rsp_valid_ff;
   logic             out_valid_ff;
   rec_type          out_rec_ff;
   logic [6:0]       occ_ff;
   logic             empty_ff, full_ff, drop_ff;

   // store and scan hookup
   logic             wr_en, rd_en;
   logic [IW-1:0]    wr_addr, rd_addr;
   rec_type          wr_data, rd_data, push_rec;
   scan_ctl_type     scan_ctl;
   logic [IW-1:0]    best_idx;
   rec_type          best_rec;

   logic             accept;
   logic             rsp_free;
   logic             scan_done;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_done = rd_vld_ff && (rd_idx_ff == (cnt_ff - CW'(1)));

   assign push_rec = '{cell_idx: req_in_cell, cost: req_in_cost,
                       turn: req_in_turn, run: req_in_run};

   assign scan_ctl = '{vld:      rd_vld_ff && (state_ff == ST_SCAN),
                       first:    (rd_idx_ff == '0),
                       want_max: want_max_ff};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      want_max_in  = want_max_ff;
      res_valid_in = res_valid_ff;
      res_rec_in   = res_rec_ff;
      res_drop_in  = res_drop_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[IW-1:0];
      wr_data      = push_rec;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[IW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_valid_in = 1'b0;
               res_rec_in   = '0;
               res_drop_in  = 1'b0;
               want_max_in  = (req_type == REQ_POP_MAX);
               issue_in     = '0;
               state_in     = ST_FINISH;
               unique case (req_type)
                  REQ_PUSH: begin
                     if (cnt_ff < DEPTH_C) begin
                        wr_en  = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                     end else begin
                        res_drop_in = 1'b1;
                     end
                  end
                  REQ_POP_MIN, REQ_POP_MAX: begin
                     if (cnt_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_POP_LAST: begin
                     if (cnt_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = IW'(cnt_ff - CW'(1));
                        cnt_in   = cnt_ff - CW'(1);
                        state_in = ST_LAST;
                     end
                  end
                  REQ_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                     // unused codes report status only
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < cnt_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CW'(1);
            end
            if (scan_done) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            // read data still holds the newest entry
            wr_en        = 1'b1;
            wr_addr      = best_idx;
            wr_data      = rd_data;
            res_valid_in = 1'b1;
            res_rec_in   = best_rec;
            cnt_in       = cnt_ff - CW'(1);
            state_in     = ST_FINISH;
         end
         ST_LAST: begin
            res_valid_in = 1'b1;
            res_rec_in   = rd_data;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      rd_idx_ff    <= issue_ff;
      want_max_ff  <= want_max_in;
      res_valid_ff <= res_valid_in;
      res_rec_ff   <= res_rec_in;
      res_drop_ff  <= res_drop_in;
   end

   // output register: loads in FINISH once the slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && rsp_free) begin
         out_valid_ff <= res_valid_ff;
         out_rec_ff   <= res_rec_ff;
         occ_ff       <= 7'(cnt_ff);
         empty_ff     <= (cnt_ff == '0);
         full_ff      <= (cnt_ff == DEPTH_C);
         drop_ff      <= res_drop_ff;
      end
   end

   mmpq_mem #(
      .DEPTH (QUEUE_DEPTH),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mmpq_scan #(
      .IW (IW)
   ) u_scan (
      .clock    (clock),
      .ctl      (scan_ctl),
      .idx      (rd_idx_ff[IW-1:0]),
      .rec      (rd_data),
      .best_idx (best_idx),
      .best_rec (best_rec)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_cell     = out_rec_ff.cell_idx;
   assign rsp_out_cost     = out_rec_ff.cost;
   assign rsp_out_turn     = out_rec_ff.turn;
   assign rsp_out_run      = out_rec_ff.run;
   assign rsp_occupancy    = occ_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;
   assign rsp_push_dropped = drop_ff;

endmodule

// ===== rtl/mmpq_checker.sv =====
// ----------------------------------------------------------------------------
// mmpq_checker - port-level checks for the priority queue
// Watches the response channel and the flags it reports.
// ----------------------------------------------------------------------------
module mmpq_checker
   import mmpq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_out_valid,
   input logic [9:0]  rsp_out_cell,
   input logic [15:0] rsp_out_cost,
   input logic [7:0]  rsp_out_turn,
   input logic [7:0]  rsp_out_run,
   input logic [6:0]  rsp_occupancy,
   input logic        rsp_is_empty,
   input logic        rsp_is_full,
   input logic        rsp_push_dropped
);

   // a stalled beat holds its valid, cost, occupancy and record-valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_cost)
         && $stable(rsp_occupancy) && $stable(rsp_out_valid))
      else $error("response beat changed while stalled");

   // no record means all record fields read zero
   a_zero_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> (rsp_out_cell == '0) && (rsp_out_cost == '0)
         && (rsp_out_turn == '0) && (rsp_out_run == '0))
      else $error("record fields set without a popped record");

   // a dropped push only happens on a full queue and returns no record
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_dropped |-> rsp_is_full && !rsp_out_valid && !rsp_is_empty)
      else $error("push dropped while queue not full");

   // empty flag agrees with occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_occupancy == '0) && !rsp_is_full)
      else $error("empty flag disagrees with occupancy");

endmodule

bind min_max_priority_queue_top mmpq_checker u_mmpq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_valid    (rsp_out_valid),
   .rsp_out_cell     (rsp_out_cell),
   .rsp_out_cost     (rsp_out_cost),
   .rsp_out_turn     (rsp_out_turn),
   .rsp_out_run      (rsp_out_run),
   .rsp_occupancy    (rsp_occupancy),
   .rsp_is_empty     (rsp_is_empty),
   .rsp_is_full      (rsp_is_full),
   .rsp_push_dropped (rsp_push_dropped)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for min_max_priority_queue_top
// Drives push, pop-min, pop-max, pop-last, clear and unused request codes
// with random gaps and response stalls. A behavioral copy of the queue
// predicts each response beat, which is then checked field by field.
// ----------------------------------------------------------------------------
module tb
   import mmpq_pkg::*;
();

   localparam int unsigned QUEUE_DEPTH = 64;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   // request codes the block ignores
   localparam logic [REQ_W-1:0] REQ_RESERVED_LO = 3'd5;
   localparam logic [REQ_W-1:0] REQ_RESERVED_HI = 3'd7;

   typedef struct {
      logic       out_valid;
      rec_type    rec;
      logic [6:0] occupancy;
      logic       is_empty;
      logic       is_full;
      logic       push_dropped;
   } response_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [REQ_W-1:0] req_type = REQ_PUSH;
   logic [9:0]       req_in_cell = '0;
   logic [15:0]      req_in_cost = '0;
   logic [7:0]       req_in_turn = '0;
   logic [7:0]       req_in_run = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_out_valid;
   logic [9:0]       rsp_out_cell;
   logic [15:0]      rsp_out_cost;
   logic [7:0]       rsp_out_turn;
   logic [7:0]       rsp_out_run;
   logic [6:0]       rsp_occupancy;
   logic             rsp_is_empty;
   logic             rsp_is_full;
   logic             rsp_push_dropped;

   // shadow copy of the queue contents and fill level
   rec_type      queue_image [QUEUE_DEPTH];
   int unsigned  queue_fill = 0;
   // response beats predicted but not yet seen
   response_type pending_responses [$];
   response_type head_response;

   int          error_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b0;   // sender inserts gaps
   bit          stall_on = 1'b0;  // receiver stalls
   int          stall_hold = 0;

   min_max_priority_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_in_cell      (req_in_cell),
      .req_in_cost      (req_in_cost),
      .req_in_turn      (req_in_turn),
      .req_in_run       (req_in_run),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_cell     (rsp_out_cell),
      .rsp_out_cost     (rsp_out_cost),
      .rsp_out_turn     (rsp_out_turn),
      .rsp_out_run      (rsp_out_run),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .rsp_push_dropped (rsp_push_dropped)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Queue behavior: apply one request to the shadow copy and return the
   // response beat it should produce.
   // ---------------------------------------------------------------------
   function automatic response_type predict_response(input logic [REQ_W-1:0] kind,
                                                     input rec_type rec);
      response_type r;
      int unsigned  pick;
      int unsigned  i;
      logic         want_max;
      r.out_valid    = 1'b0;
      r.rec          = '0;
      r.push_dropped = 1'b0;
      case (kind)
         REQ_PUSH: begin
            if (queue_fill >= QUEUE_DEPTH) begin
               r.push_dropped = 1'b1;
            end else begin
               queue_image[queue_fill] = rec;
               queue_fill++;
            end
         end
         REQ_POP_MIN, REQ_POP_MAX: begin
            if (queue_fill > 0) begin
               // linear scan on cost; >= / <= lets the later index win a tie
               want_max = (kind == REQ_POP_MAX);
               pick = 0;
               for (i = 0; i < queue_fill; i++) begin
                  if (want_max ? (queue_image[i].cost >= queue_image[pick].cost)
                               : (queue_image[i].cost <= queue_image[pick].cost))
                     pick = i;
               end
               r.rec = queue_image[pick];
               r.out_valid = 1'b1;
               // newest entry fills the hole
               queue_fill--;
               queue_image[pick] = queue_image[queue_fill];
            end
         end
         REQ_POP_LAST: begin
            if (queue_fill > 0) begin
               queue_fill--;
               r.rec = queue_image[queue_fill];
               r.out_valid = 1'b1;
            end
         end
         REQ_CLEAR: begin
            queue_fill = 0;
         end
         default: ;
      endcase
      r.occupancy = queue_fill[6:0];
      r.is_empty  = (queue_fill == 0);
      r.is_full   = (queue_fill == QUEUE_DEPTH);
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 0;
      else if (roll < 94)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [REQ_W-1:0] pick_kind(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         return REQ_PUSH;
      roll = $urandom_range(0, 99);
      if (roll < 33)
         return REQ_POP_MIN;
      else if (roll < 66)
         return REQ_POP_MAX;
      else if (roll < 94)
         return REQ_POP_LAST;
      else if (roll < 97)
         return REQ_CLEAR;
      else
         return REQ_W'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one beat per call. Valid stays high between back-to-back
   // beats; the expectation is queued at the accepting edge.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [9:0] cell_idx,
                               input logic [15:0] cost, input logic [7:0] turn,
                               input logic [7:0] run);
      int      gap;
      rec_type rec;
      gap = idle_on ? pick_gap() : 0;
      rec.cell_idx = cell_idx;
      rec.cost     = cost;
      rec.turn     = turn;
      rec.run      = run;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_in_cell <= cell_idx;
      req_in_cost <= cost;
      req_in_turn <= turn;
      req_in_run  <= run;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_responses.push_back(predict_response(kind, rec));
   endtask

   // random payload; narrow costs crowd the keys together to force ties
   task automatic send_random(input logic [REQ_W-1:0] kind, input bit narrow);
      send_request(kind, 10'($urandom_range(0, 1023)),
                   narrow ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // valid drops first so the last beat is not offered again
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side: check each accepted beat against the oldest expectation,
   // then hold or re-roll the stall for the next cycle.
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $error("response beat with nothing expected");
            error_count++;
         end else begin
            head_response = pending_responses.pop_front();
            check_field("out_valid", head_response.out_valid, rsp_out_valid);
            check_field("out_cell", head_response.rec.cell_idx, rsp_out_cell);
            check_field("out_cost", head_response.rec.cost, rsp_out_cost);
            check_field("out_turn", head_response.rec.turn, rsp_out_turn);
            check_field("out_run", head_response.rec.run, rsp_out_run);
            check_field("occupancy", head_response.occupancy, rsp_occupancy);
            check_field("is_empty", head_response.is_empty, rsp_is_empty);
            check_field("is_full", head_response.is_full, rsp_is_full);
            check_field("push_dropped", head_response.push_dropped, rsp_push_dropped);
         end
      end
      // stall level held for a random stretch, then re-rolled
      if (stall_hold == 0) begin
         rsp_stall  <= stall_on && ($urandom_range(0, 2) == 0);
         stall_hold <= pick_gap();
      end else begin
         stall_hold <= stall_hold - 1;
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // every pop kind, clear and the lowest and highest unused codes on an empty queue
   task automatic test_empty_queue();
      idle_on  = 1'b0;
      stall_on = 1'b0;
      send_request(REQ_POP_MIN, 10'h3FF, 16'hFFFF, 8'hFF, 8'hFF);
      send_request(REQ_POP_MAX, 10'h000, 16'h0000, 8'h00, 8'h00);
      send_request(REQ_POP_LAST, 10'h155, 16'hAAAA, 8'h55, 8'hAA);
      send_request(REQ_CLEAR, 10'h2AA, 16'h5555, 8'hAA, 8'h55);
      send_request(REQ_RESERVED_LO, 10'h3FF, 16'hFFFF, 8'hFF, 8'hFF);
      send_request(REQ_RESERVED_HI, 10'h000, 16'h0000, 8'h00, 8'h00);
   endtask

   // field extremes, ties at both ends of the cost range, every pop kind
   task automatic test_extremes_and_ties();
      idle_on  = 1'b1;
      stall_on = 1'b1;
      send_request(REQ_PUSH, 10'h3FF, 16'hFFFF, 8'hFF, 8'hFF);
      send_request(REQ_PUSH, 10'h000, 16'h0000, 8'h00, 8'h00);
      send_request(REQ_PUSH, 10'h200, 16'd100, 8'hAA, 8'h55);
      send_request(REQ_PUSH, 10'h001, 16'd100, 8'h55, 8'hAA);
      send_request(REQ_PUSH, 10'h002, 16'hFFFF, 8'h01, 8'h80);
      send_request(REQ_PUSH, 10'h003, 16'h0000, 8'h80, 8'h01);
      send_request(REQ_POP_MAX, '0, '0, '0, '0);   // later max-cost tie
      send_request(REQ_POP_MIN, '0, '0, '0, '0);   // later min-cost tie
      send_request(REQ_POP_MIN, '0, '0, '0, '0);
      send_request(REQ_POP_LAST, '0, '0, '0, '0);
      send_request(REQ_RESERVED_LO + 3'd1, '0, '0, '0, '0);
      send_request(REQ_POP_MAX, '0, '0, '0, '0);
      send_request(REQ_PUSH, 10'h155, 16'h8000, 8'h7F, 8'hFE);
      send_request(REQ_CLEAR, '0, '0, '0, '0);
      send_request(REQ_POP_LAST, '0, '0, '0, '0);  // empty after clear
      send_request(REQ_POP_MAX, '0, '0, '0, '0);
   endtask

   // fill past full (dropped pushes), pause for all beats, then drain past empty
   task automatic test_fill_and_drain(input int rounds);
      int          round;
      int unsigned extra;
      for (round = 0; round < rounds; round++) begin
         idle_on  = (round % 3 != 0);
         stall_on = (round % 2 == 1);
         while (queue_fill < QUEUE_DEPTH)
            send_random(REQ_PUSH, (round % 2) == 1);
         extra = $urandom_range(1, 3);
         repeat (extra) send_random(REQ_PUSH, (round % 2) == 1);
         // hold off the next request until the queue has answered everything
         wait_for_responses();
         while (queue_fill > 0)
            send_random(pick_kind(0) == REQ_POP_MIN ? REQ_POP_MIN :
                        ($urandom_range(0, 1) ? REQ_POP_MAX : REQ_POP_LAST), 1'b0);
         send_random(REQ_POP_MIN, 1'b0);
      end
   endtask

   // mixed traffic; stretches with and without gaps and stalls
   task automatic test_random_mix(input int count, input int push_pct, input bit narrow);
      int n;
      for (n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            idle_on  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
         end
         send_random(pick_kind(push_pct), narrow);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_extremes_and_ties();
      test_random_mix(700, 55, 1'b0);
      test_fill_and_drain(5);
      test_random_mix(300, 60, 1'b1);

      req_valid <= 1'b0;
      stall_on = 1'b0;
      wait_for_responses();
      // catch any stray beat after the last expected one
      repeat (QUEUE_DEPTH + 8) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mmpq_pkg.sv
rtl/mmpq_mem.sv
rtl/mmpq_scan.sv
rtl/min_max_priority_queue_top.sv
rtl/mmpq_checker.sv
bench/tb.sv
